// ===== hdl/c3rgb_pkg.sv =====
// c3rgb_pkg: shared types, constants and register indexes of the 3x3 rgb filter
// used by c3rgb_window, c3rgb_filter and conv3x3_rgb_clamped_edges
// no dependencies
package c3rgb_pkg;

  // geometry
  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned KSIZE         = 3;
  localparam int unsigned NTAPS         = KSIZE * KSIZE;
  localparam int unsigned NCH           = 3;
  localparam int unsigned PIX_W         = 24;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned COEF_W        = 16;
  localparam int unsigned KROW_W        = KSIZE * COEF_W;

  // configuration register widths and reset values
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned IMG_W_W     = 12;
  localparam int unsigned IMG_H_W     = 16;
  localparam logic [KROW_W-1:0] KROW_TOP_RST = 48'h0000_0000_0000;
  localparam logic [KROW_W-1:0] KROW_MID_RST = 48'h0000_0100_0000;
  localparam logic [KROW_W-1:0] KROW_BOT_RST = 48'h0000_0000_0000;

  // arithmetic widths
  localparam int unsigned PROD_W = 24;
  localparam int unsigned RSUM_W = 26;
  localparam int unsigned TSUM_W = 28;
  localparam int unsigned CH_MAX = 255;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_KROW_TOP     = 3'd2,
    CFG_KROW_MID     = 3'd3,
    CFG_KROW_BOT     = 3'd4
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_t;
  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_t;

  // request from the counter stage into the window stage
  typedef struct packed {
    pix_t pix;
    logic wr_only;   // first image row: only fill the line stores
    logic fill;      // column zero: load every window column
    logic last;      // last column of the row
    logic flush;     // flush row: bottom row repeats the lower line store
  } win_req_t;

  // window handed to the filter
  typedef struct packed {
    win_t win;
    logic row_end;
    logic frame_end;
  } emit_t;

endpackage

// ===== hdl/c3rgb_ram.sv =====
// c3rgb_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module c3rgb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/c3rgb_window.sv =====
// c3rgb_window: two line stores and the 3x3 window register
// depends on c3rgb_pkg and c3rgb_ram
module c3rgb_window #(
  parameter int unsigned MAX_WIDTH = c3rgb_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  c3rgb_pkg::win_req_t          req_i,
  output logic                         free_o,
  output logic                         emit_valid_o,
  output c3rgb_pkg::emit_t             emit_o,
  input  logic                         emit_ready_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic                 s1_v_q, s1_v_d;
  logic                 rep_q, rep_d;
  logic [AW-1:0]        addr_q;
  c3rgb_pkg::win_req_t  req_q;
  logic                 fwd_q;
  c3rgb_pkg::pix_t      fwd_up_q, fwd_lo_q;
  c3rgb_pkg::win_t      win_q, win_d;

  c3rgb_pkg::pix_t      up_rdata, lo_rdata;
  c3rgb_pkg::pix_t      top, mid, bot;
  c3rgb_pkg::pix_t      up_wdata, lo_wdata;
  logic                 emits, act, wr_en, to_rep;

  // line stores: upper holds row r-2, lower holds row r-1
  c3rgb_ram #(.WIDTH(c3rgb_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr_q),
    .wdata_i (up_wdata),
    .re_i    (load_i),
    .raddr_i (addr_i),
    .rdata_o (up_rdata)
  );

  c3rgb_ram #(.WIDTH(c3rgb_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr_q),
    .wdata_i (lo_wdata),
    .re_i    (load_i),
    .raddr_i (addr_i),
    .rdata_o (lo_rdata)
  );

  // column taken from the line stores, forwarded when written in the read cycle
  assign top = fwd_q ? fwd_up_q : up_rdata;
  assign mid = fwd_q ? fwd_lo_q : lo_rdata;
  assign bot = req_q.flush ? mid : req_q.pix;

  assign up_wdata = req_q.wr_only ? req_q.pix : mid;
  assign lo_wdata = req_q.wr_only ? req_q.pix : bot;

  // stage control: the repeat step emits the second result of a row end
  assign emits  = rep_q || (!req_q.wr_only && !req_q.fill);
  assign act    = s1_v_q && (!emits || emit_ready_i);
  assign wr_en  = act && !rep_q;
  assign to_rep = !rep_q && req_q.last && !req_q.wr_only;
  assign free_o = !s1_v_q || (act && !to_rep);

  always_comb begin
    s1_v_d = s1_v_q;
    rep_d  = rep_q;
    if (act) begin
      if (to_rep) begin
        rep_d = 1'b1;
      end else begin
        rep_d  = 1'b0;
        s1_v_d = load_i;
      end
    end else if (!s1_v_q) begin
      s1_v_d = load_i;
    end
  end

  // window update: fill at column zero, shift otherwise, repeat edge on row end
  always_comb begin
    win_d = win_q;
    if (act && (rep_q || !req_q.wr_only)) begin
      for (int r = 0; r < c3rgb_pkg::KSIZE; r++) begin
        for (int k = 0; k < c3rgb_pkg::KSIZE - 1; k++) begin
          win_d[r][k] = win_q[r][k+1];
        end
      end
      if (rep_q) begin
        for (int r = 0; r < c3rgb_pkg::KSIZE; r++) begin
          win_d[r][c3rgb_pkg::KSIZE-1] = win_q[r][c3rgb_pkg::KSIZE-1];
        end
      end else if (req_q.fill) begin
        for (int k = 0; k < c3rgb_pkg::KSIZE; k++) begin
          win_d[0][k] = top;
          win_d[1][k] = mid;
          win_d[2][k] = bot;
        end
      end else begin
        win_d[0][c3rgb_pkg::KSIZE-1] = top;
        win_d[1][c3rgb_pkg::KSIZE-1] = mid;
        win_d[2][c3rgb_pkg::KSIZE-1] = bot;
      end
    end
  end

  assign emit_valid_o     = s1_v_q && emits;
  assign emit_o.win       = win_d;
  assign emit_o.row_end   = rep_q;
  assign emit_o.frame_end = rep_q && req_q.flush;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      rep_q  <= 1'b0;
      win_q  <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      rep_q  <= rep_d;
      win_q  <= win_d;
    end
  end

  // request and forwarding registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      addr_q   <= addr_i;
      req_q    <= req_i;
      fwd_q    <= wr_en && (addr_q == addr_i);
      fwd_up_q <= up_wdata;
      fwd_lo_q <= lo_wdata;
    end
  end

endmodule

// ===== hdl/c3rgb_filter.sv =====
// c3rgb_filter: multiply, row sums, total and clamp, ending in the output register
// depends on c3rgb_pkg
module c3rgb_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  c3rgb_pkg::emit_t    in_i,
  input  c3rgb_pkg::kernel_t  kernel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [c3rgb_pkg::PIX_W-1:0] out_rgb_o,
  output logic                out_re_o,
  output logic                out_fe_o
);

  localparam int unsigned K  = c3rgb_pkg::KSIZE;
  localparam int unsigned NT = c3rgb_pkg::NTAPS;
  localparam int unsigned NC = c3rgb_pkg::NCH;

  typedef logic signed [c3rgb_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [c3rgb_pkg::RSUM_W-1:0] rsum_t;
  typedef logic signed [c3rgb_pkg::TSUM_W-1:0] tsum_t;

  logic a_v_q, b_v_q, c_v_q, o_v_q;
  logic a_rdy, b_rdy, c_rdy, o_rdy;
  c3rgb_pkg::emit_t a_q;
  prod_t   prod_d [NC][NT];
  prod_t   prod_q [NC][NT];
  logic    b_re_q, b_fe_q, c_re_q, c_fe_q;
  rsum_t   rsum_d [NC][K];
  rsum_t   rsum_q [NC][K];
  logic [c3rgb_pkg::PIX_W-1:0] rgb_d, rgb_q;
  logic    o_re_q, o_fe_q;

  // stage handshake
  assign o_rdy      = !o_v_q || out_ready_i;
  assign c_rdy      = !c_v_q || o_rdy;
  assign b_rdy      = !b_v_q || c_rdy;
  assign a_rdy      = !a_v_q || b_rdy;
  assign in_ready_o = a_rdy;

  // products of each tap and channel
  always_comb begin
    logic signed [c3rgb_pkg::CH_W:0]     px;
    logic signed [c3rgb_pkg::COEF_W-1:0] cf;
    logic signed [c3rgb_pkg::PROD_W:0]   p;
    for (int ch = 0; ch < NC; ch++) begin
      for (int t = 0; t < NT; t++) begin
        px = $signed({1'b0, a_q.win[t/K][t%K][ch*c3rgb_pkg::CH_W +: c3rgb_pkg::CH_W]});
        cf = $signed(kernel_i[t/K][(t%K)*c3rgb_pkg::COEF_W +: c3rgb_pkg::COEF_W]);
        p  = (c3rgb_pkg::PROD_W+1)'(px * cf);
        prod_d[ch][t] = p[c3rgb_pkg::PROD_W-1:0];
      end
    end
  end

  // sums over each kernel row
  always_comb begin
    for (int ch = 0; ch < NC; ch++) begin
      for (int r = 0; r < K; r++) begin
        rsum_d[ch][r] = rsum_t'(prod_q[ch][r*K]) + rsum_t'(prod_q[ch][r*K+1])
                      + rsum_t'(prod_q[ch][r*K+2]);
      end
    end
  end

  // total, drop fraction, clamp to 0..255
  always_comb begin
    tsum_t tot;
    for (int ch = 0; ch < NC; ch++) begin
      tot = tsum_t'(rsum_q[ch][0]) + tsum_t'(rsum_q[ch][1]) + tsum_t'(rsum_q[ch][2]);
      if (tot <= 0) begin
        rgb_d[ch*c3rgb_pkg::CH_W +: c3rgb_pkg::CH_W] = '0;
      end else if (tot[c3rgb_pkg::TSUM_W-2:c3rgb_pkg::CH_W] > c3rgb_pkg::CH_MAX) begin
        rgb_d[ch*c3rgb_pkg::CH_W +: c3rgb_pkg::CH_W] = c3rgb_pkg::CH_W'(c3rgb_pkg::CH_MAX);
      end else begin
        rgb_d[ch*c3rgb_pkg::CH_W +: c3rgb_pkg::CH_W] =
          tot[2*c3rgb_pkg::CH_W-1:c3rgb_pkg::CH_W];
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= in_valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (o_rdy) o_v_q <= c_v_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_q <= in_i;
    end
    if (b_rdy) begin
      prod_q <= prod_d;
      b_re_q <= a_q.row_end;
      b_fe_q <= a_q.frame_end;
    end
    if (c_rdy) begin
      rsum_q <= rsum_d;
      c_re_q <= b_re_q;
      c_fe_q <= b_fe_q;
    end
    if (o_rdy) begin
      rgb_q  <= rgb_d;
      o_re_q <= c_re_q;
      o_fe_q <= c_fe_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_rgb_o   = rgb_q;
  assign out_re_o    = o_re_q;
  assign out_fe_o    = o_fe_q;

endmodule

// ===== hdl/conv3x3_rgb_clamped_edges.sv =====
// Streams rgb pixels in raster order and returns each pixel filtered by a 3x3 kernel of
// signed Q8.8 coefficients, with edge pixels replicated and results clamped to 0..255.
// One pixel is taken every clock while the output is not stalled; at the end of each row
// the window stage holds off input while it makes the row's last result, except in the
// first row of a frame, which only fills the line stores. Results lag the input by one
// row and one column and leave after five register stages; after the last row send
// image_width flush requests to drain the final row. The line stores need no clearing
// pass, so the block accepts requests straight after reset. The user must write the
// configuration only while the block is idle; the block itself does not enforce this.
// depends on c3rgb_pkg, c3rgb_window and c3rgb_filter
module conv3x3_rgb_clamped_edges #(
  parameter int unsigned MAX_WIDTH = c3rgb_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  input  logic [0:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
  output logic        m_axis_tlast,   // row_end
  output logic [0:0]  m_axis_tuser,   // frame_end
  input  logic        cfg_we_i,
  input  logic [c3rgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [c3rgb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned CW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (CW > c3rgb_pkg::IMG_W_W) ? CW : c3rgb_pkg::IMG_W_W;

  logic [c3rgb_pkg::IMG_W_W-1:0] width_q;
  logic [c3rgb_pkg::IMG_H_W-1:0] height_q;
  c3rgb_pkg::kernel_t            kernel_q;

  logic [AW-1:0]                 col_q, col_d;
  logic [c3rgb_pkg::IMG_H_W-1:0] row_q, row_d;

  logic [CMPW-1:0]               w_ext, w_eff;
  logic [c3rgb_pkg::IMG_H_W-1:0] h_eff;
  logic                          flushrow, last, drop, accept, load;
  c3rgb_pkg::win_req_t           req;
  logic                          win_free, emit_valid, emit_ready;
  c3rgb_pkg::emit_t              emit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= c3rgb_pkg::IMG_W_W'(1);
      height_q    <= c3rgb_pkg::IMG_H_W'(1);
      kernel_q[0] <= c3rgb_pkg::KROW_TOP_RST;
      kernel_q[1] <= c3rgb_pkg::KROW_MID_RST;
      kernel_q[2] <= c3rgb_pkg::KROW_BOT_RST;
    end else if (cfg_we_i) begin
      unique case (c3rgb_pkg::cfg_idx_e'(cfg_idx_i))
        c3rgb_pkg::CFG_IMAGE_WIDTH:  width_q     <= cfg_data_i[c3rgb_pkg::IMG_W_W-1:0];
        c3rgb_pkg::CFG_IMAGE_HEIGHT: height_q    <= cfg_data_i[c3rgb_pkg::IMG_H_W-1:0];
        c3rgb_pkg::CFG_KROW_TOP:     kernel_q[0] <= cfg_data_i[c3rgb_pkg::KROW_W-1:0];
        c3rgb_pkg::CFG_KROW_MID:     kernel_q[1] <= cfg_data_i[c3rgb_pkg::KROW_W-1:0];
        c3rgb_pkg::CFG_KROW_BOT:     kernel_q[2] <= cfg_data_i[c3rgb_pkg::KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // effective image size
  always_comb begin
    w_ext = CMPW'(width_q);
    if (w_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (height_q == '0) ? c3rgb_pkg::IMG_H_W'(1) : height_q;
  end

  // position of the incoming request
  assign flushrow = row_q >= h_eff;
  assign last     = (CMPW'(col_q) + CMPW'(1)) >= w_eff;
  assign drop     = s_axis_tuser[0] && !flushrow;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign load     = accept && !drop;

  assign req.pix     = s_axis_tdata;
  assign req.wr_only = (row_q == '0) && !flushrow;
  assign req.fill    = (col_q == '0);
  assign req.last    = last;
  assign req.flush   = flushrow;

  // column and row counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (load) begin
      if (last) begin
        col_d = '0;
        row_d = flushrow ? '0 : row_q + c3rgb_pkg::IMG_H_W'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign s_axis_tready = win_free;

  c3rgb_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .addr_i       (col_q),
    .req_i        (req),
    .free_o       (win_free),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .emit_ready_i (emit_ready)
  );

  c3rgb_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (emit_valid),
    .in_ready_o  (emit_ready),
    .in_i        (emit),
    .kernel_i    (kernel_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rgb_o   (m_axis_tdata),
    .out_re_o    (m_axis_tlast),
    .out_fe_o    (m_axis_tuser[0])
  );

endmodule
